### design/clc_pkg.sv
package clc_pkg;

    localparam int CAND_W     = 8;
    localparam int SEL_W      = 3;
    localparam int NUM_MUX    = 4;
    localparam int NUM_GATE   = 4;
    localparam int GSEL_W     = 2 * NUM_MUX;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    typedef enum logic [2:0] {
        MODE_AND_OR  = 3'd0,
        MODE_OR_XOR  = 3'd1,
        MODE_AND4    = 3'd2,
        MODE_SR      = 3'd3,
        MODE_DFF_SR  = 3'd4,
        MODE_DFF_2IN = 3'd5,
        MODE_JKFF    = 3'd6,
        MODE_LATCH   = 3'd7
    } cell_mode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CELL_MODE       = 3'd0,
        REG_CELL_ENABLE     = 3'd1,
        REG_RISE_IRQ_ENABLE = 3'd2,
        REG_FALL_IRQ_ENABLE = 3'd3,
        REG_GATE_POLARITY   = 3'd4,
        REG_OUTPUT_POLARITY = 3'd5,
        REG_DATA_SELECT     = 3'd6,
        REG_GATE_SELECT     = 3'd7
    } cfg_index_t;

    // one 3-bit select field per data multiplexer, mux1 lowest
    typedef logic [NUM_MUX*SEL_W-1:0]    data_select_t;
    typedef logic [NUM_GATE*GSEL_W-1:0]  gate_select_t;

    typedef struct packed {
        cell_mode_t             cell_mode;
        logic                   cell_enable;
        logic                   rise_irq_enable;
        logic                   fall_irq_enable;
        logic [NUM_GATE-1:0]    gate_polarity;
        logic                   output_polarity;
        data_select_t           data_select;
        gate_select_t           gate_select;
    } cfg_t;

endpackage

### design/clc_in_if.sv
interface clc_in_if;
    import clc_pkg::*;

    logic              valid;
    logic              ready;
    logic [CAND_W-1:0] mux1_candidates;
    logic [CAND_W-1:0] mux2_candidates;
    logic [CAND_W-1:0] mux3_candidates;
    logic [CAND_W-1:0] mux4_candidates;

    modport source
    (
        output valid,
        output mux1_candidates,
        output mux2_candidates,
        output mux3_candidates,
        output mux4_candidates,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  mux1_candidates,
        input  mux2_candidates,
        input  mux3_candidates,
        input  mux4_candidates,
        output ready
    );

endinterface

### design/clc_out_if.sv
interface clc_out_if;
    import clc_pkg::*;

    logic                valid;
    logic                ready;
    logic                cell_output;
    logic                irq_pulse;
    logic [NUM_GATE-1:0] gate_levels;

    modport source
    (
        output valid,
        output cell_output,
        output irq_pulse,
        output gate_levels,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  cell_output,
        input  irq_pulse,
        input  gate_levels,
        output ready
    );

endinterface

### design/configurable_logic_cell.sv
// Configurable logic cell.
// sample: one request carries the levels of the eight candidates of each of
//   the four data multiplexers. result: one request per sample, with the
//   registered cell output, the edge interrupt pulse and the four gate levels.
// Configuration: cfg_we/cfg_index/cfg_data write one register per cycle;
//   write only while no sample is in flight.
// Path: a sample taken into the input register passes through the mux, gate
//   and cell logic into the result register, where it is offered on result.
// Throughput: one sample per cycle while result is not held; the datapath is
//   a single pass of mux, gate and cell logic between the two registers.
// The cell's own state (latch, last clock gate, output level) advances once
//   per sample, in sample order, as the sample moves into the result register.
// Reset: all configuration registers, cell state and valid flags clear.
// Stall: while result is held, the result register keeps its request and the
//   input register keeps one more; sample.ready drops only when both are full.
module configurable_logic_cell
(
    input  logic                            clk,
    input  logic                            rst_n,
    clc_in_if.sink                          sample,
    clc_out_if.source                       result,
    input  logic                            cfg_we,
    input  logic [clc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [clc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import clc_pkg::*;

    cfg_t                         cfg_reg;

    logic                         in_valid_reg;
    logic [NUM_MUX-1:0][CAND_W-1:0] cand_reg;

    logic                         latch_reg;
    logic                         latch_next;
    logic                         prev_clk_reg;
    logic                         prev_clk_next;
    logic                         level_reg;
    logic                         level_next;

    logic                         out_valid_reg;
    logic                         cell_output_reg;
    logic                         irq_reg;
    logic                         irq_next;
    logic [NUM_GATE-1:0]          gate_reg;

    logic                         out_free;
    logic                         advance;
    logic [NUM_MUX-1:0]           d;
    logic [GSEL_W-1:0]            term;
    logic [NUM_GATE-1:0]          g;
    logic                         rising;
    logic                         res;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CELL_MODE:       cfg_reg.cell_mode       <= cell_mode_t'(cfg_data[2:0]);
                REG_CELL_ENABLE:     cfg_reg.cell_enable     <= cfg_data[0];
                REG_RISE_IRQ_ENABLE: cfg_reg.rise_irq_enable <= cfg_data[0];
                REG_FALL_IRQ_ENABLE: cfg_reg.fall_irq_enable <= cfg_data[0];
                REG_GATE_POLARITY:   cfg_reg.gate_polarity   <= cfg_data[NUM_GATE-1:0];
                REG_OUTPUT_POLARITY: cfg_reg.output_polarity <= cfg_data[0];
                REG_DATA_SELECT:     cfg_reg.data_select     <= cfg_data[NUM_MUX*SEL_W-1:0];
                REG_GATE_SELECT:     cfg_reg.gate_select     <= cfg_data[NUM_GATE*GSEL_W-1:0];
                default:             cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    // ---------------- handshake ----------------
    assign out_free     = !out_valid_reg || result.ready;
    assign advance      = in_valid_reg && out_free;
    assign sample.ready = !in_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (sample.ready)
        begin
            in_valid_reg <= sample.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample.ready && sample.valid)
        begin
            cand_reg[0] <= sample.mux1_candidates;
            cand_reg[1] <= sample.mux2_candidates;
            cand_reg[2] <= sample.mux3_candidates;
            cand_reg[3] <= sample.mux4_candidates;
        end
    end

    // ---------------- data muxes and gates ----------------
    always_comb
    begin
        for (int m = 0; m < NUM_MUX; m++)
        begin
            d[m]          = cand_reg[m][cfg_reg.data_select[m*SEL_W +: SEL_W]];
            term[2*m]     = ~d[m];
            term[2*m + 1] = d[m];
        end
        for (int j = 0; j < NUM_GATE; j++)
        begin
            g[j] = (|(cfg_reg.gate_select[j*GSEL_W +: GSEL_W] & term))
                   ^ cfg_reg.gate_polarity[j];
        end
    end

    // ---------------- cell function ----------------
    assign rising = g[0] && !prev_clk_reg;

    always_comb
    begin
        latch_next    = latch_reg;
        prev_clk_next = prev_clk_reg;
        res           = 1'b0;
        case (cfg_reg.cell_mode)
            MODE_AND_OR:
            begin
                res = (g[0] && g[1]) || (g[2] && g[3]);
            end
            MODE_OR_XOR:
            begin
                res = (g[0] || g[1]) ^ (g[2] || g[3]);
            end
            MODE_AND4:
            begin
                res = &g;
            end
            MODE_SR:
            begin
                if (g[0] || g[1])
                    latch_next = 1'b1;
                else if (g[2] || g[3])
                    latch_next = 1'b0;
                res = latch_next;
            end
            MODE_DFF_SR:
            begin
                if (g[3])
                    latch_next = 1'b1;
                else if (g[2])
                    latch_next = 1'b0;
                else if (rising)
                    latch_next = g[1];
                prev_clk_next = g[0];
                res           = latch_next;
            end
            MODE_DFF_2IN:
            begin
                if (g[2])
                    latch_next = 1'b0;
                else if (rising)
                    latch_next = g[1] || g[3];
                prev_clk_next = g[0];
                res           = latch_next;
            end
            MODE_JKFF:
            begin
                if (g[2])
                    latch_next = 1'b0;
                else if (rising)
                begin
                    if (g[1] && g[3])
                        latch_next = !latch_reg;
                    else if (g[1])
                        latch_next = 1'b1;
                    else if (g[3])
                        latch_next = 1'b0;
                end
                prev_clk_next = g[0];
                res           = latch_next;
            end
            MODE_LATCH:
            begin
                // transparent while g2 is low
                if (g[3])
                    latch_next = 1'b1;
                else if (g[0])
                    latch_next = 1'b0;
                else if (!g[2])
                    latch_next = g[1];
                res = latch_next;
            end
            default:
            begin
                res = 1'b0;
            end
        endcase
        res = res ^ cfg_reg.output_polarity;
    end

    always_comb
    begin
        level_next = level_reg;
        irq_next   = 1'b0;
        if (cfg_reg.cell_enable)
        begin
            irq_next   = (!level_reg && res && cfg_reg.rise_irq_enable)
                      || (level_reg && !res && cfg_reg.fall_irq_enable);
            level_next = res;
        end
    end

    // ---------------- state and result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latch_reg     <= 1'b0;
            prev_clk_reg  <= 1'b0;
            level_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                latch_reg    <= latch_next;
                prev_clk_reg <= prev_clk_next;
                level_reg    <= level_next;
            end
            if (out_free)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            cell_output_reg <= level_next;
            irq_reg         <= irq_next;
            gate_reg        <= g;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.cell_output = cell_output_reg;
    assign result.irq_pulse   = irq_reg;
    assign result.gate_levels = gate_reg;

    // ---------------- assertions ----------------
    a_out_tracks_level: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> cell_output_reg == level_reg)
        else $error("result output differs from output state");

    a_no_irq_disabled: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !cfg_reg.cell_enable |=> !irq_reg && $stable(level_reg))
        else $error("disabled cell changed output or raised irq");

    a_irq_on_edge: assert property (@(posedge clk) disable iff (!rst_n)
        advance && irq_next |=> level_reg != $past(level_reg))
        else $error("irq without an output edge");

    a_comb_keeps_latch: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (cfg_reg.cell_mode == MODE_AND_OR || cfg_reg.cell_mode == MODE_OR_XOR
                    || cfg_reg.cell_mode == MODE_AND4)
        |=> $stable(latch_reg) && $stable(prev_clk_reg))
        else $error("combinational mode touched cell storage");

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(cand_reg))
        else $error("stalled input register lost its request");

endmodule
